>>> hdl/clnf_pkg.sv
`default_nettype none
package clnf_pkg;

   localparam int NUM_CLUSTERS    = 4096;
   localparam int LINKS_PER_GROUP = 128;
   localparam int GROUPS          = (NUM_CLUSTERS + LINKS_PER_GROUP - 1) / LINKS_PER_GROUP;
   localparam int TABLE_DEPTH     = GROUPS * LINKS_PER_GROUP;
   localparam int OFS_W           = $clog2(LINKS_PER_GROUP);
   localparam int GRP_W           = $clog2(GROUPS);
   localparam int IDX_W           = OFS_W + GRP_W;
   localparam int TOT_W           = 13;
   localparam int LINK_W          = 32;
   localparam int CMD_W           = 2;
   localparam int STAT_W          = 2;
   localparam int REQ_W           = 48;
   localparam int RSP_W           = 48;

   localparam logic [LINK_W-1:0] FREE_MARK = '0;
   localparam logic [LINK_W-1:0] LAST_MARK = '1;

   localparam logic [CMD_W-1:0] CMD_FIND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GET  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_MOUNTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE       = 2'd2;
   localparam logic [STAT_W-1:0] ST_NO_FREE     = 2'd3;

   localparam logic CSR_MOUNTED = 1'b0;
   localparam logic CSR_TOTAL   = 1'b1;

   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_FIND = 2'd1;
   localparam logic [1:0] KIND_SET  = 2'd2;
   localparam logic [1:0] KIND_GET  = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  idx;
      logic [LINK_W-1:0] val;
   } rec_type;

   typedef struct packed {
      logic [GRP_W:0] groups;
      logic [OFS_W:0] last_cnt;
   } geom_type;

endpackage
`default_nettype wire

>>> hdl/clnf_front.sv
`default_nettype none
module clnf_front
   import clnf_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire [REQ_W-1:0]  req_tdata,
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire              csr_index,
   input  wire [TOT_W-1:0]  csr_data,
   output logic             push_valid,
   input  wire              push_ready,
   output rec_type          push_rec,
   output geom_type         geom
);

   logic             mounted_ff;
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] eff_total;
   logic [TOT_W:0]   tsum;
   logic [CMD_W-1:0] cmd;
   logic [IDX_W-1:0] idx;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         mounted_ff <= 1'b1;
         total_ff   <= TOT_W'(NUM_CLUSTERS);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MOUNTED: mounted_ff <= csr_data[0];
            CSR_TOTAL:   total_ff   <= csr_data;
            default:     ;
         endcase
      end
   end

   always_comb begin
      eff_total = (total_ff > TOT_W'(NUM_CLUSTERS)) ? TOT_W'(NUM_CLUSTERS) : total_ff;
      tsum      = {1'b0, eff_total} + (TOT_W+1)'(LINKS_PER_GROUP - 1);
      geom.groups   = tsum[OFS_W +: GRP_W+1];
      geom.last_cnt = (eff_total[OFS_W-1:0] == '0) ? (OFS_W+1)'(LINKS_PER_GROUP)
                                                   : {1'b0, eff_total[OFS_W-1:0]};
   end

   // classify: failures are settled here and go to the back as pass-through records
   always_comb begin
      cmd = req_tdata[CMD_W-1:0];
      idx = req_tdata[CMD_W +: IDX_W];
      push_rec.kind   = KIND_PASS;
      push_rec.status = ST_OK;
      push_rec.idx    = idx;
      push_rec.val    = req_tdata[CMD_W+IDX_W +: LINK_W];
      if (cmd == CMD_NONE) begin
         push_rec.kind = KIND_PASS;
      end else if (!mounted_ff) begin
         push_rec.status = ST_NOT_MOUNTED;
      end else if (cmd == CMD_FIND) begin
         if (geom.groups == '0) begin
            push_rec.status = ST_NO_FREE;
         end else begin
            push_rec.kind = KIND_FIND;
         end
      end else if ({1'b0, idx[OFS_W +: GRP_W]} >= geom.groups) begin
         push_rec.status = ST_RANGE;
      end else if (cmd == CMD_SET) begin
         push_rec.kind = KIND_SET;
      end else begin
         push_rec.kind = KIND_GET;
      end
   end

endmodule
`default_nettype wire

>>> hdl/clnf_queue.sv
`default_nettype none
module clnf_queue
   import clnf_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      push_valid,
   output logic     push_ready,
   input  rec_type  push_rec,
   output logic     pop_valid,
   input  wire      pop_ready,
   output rec_type  pop_rec
);

   rec_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_rec    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hdl/clnf_back.sv
`default_nettype none
module clnf_back
   import clnf_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              pop_valid,
   output logic             pop_ready,
   input  rec_type          pop_rec,
   input  geom_type         geom,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_FRD  = 3'd2;
   localparam logic [2:0] S_FCHK = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_DO   = 3'd5;

   logic [LINKS_PER_GROUP-1:0] free_mem [GROUPS];
   logic [LINK_W-1:0]          link_mem [TABLE_DEPTH];

   logic [2:0]                 st_ff, st_in;
   rec_type                    cur_ff, cur_in;
   logic [GRP_W-1:0]           grp_ff, grp_in;
   logic [GRP_W-1:0]           vis_ff, vis_in;
   logic [GRP_W-1:0]           last_group_ff, last_group_in;
   logic                       written0_ff, written0_in;
   logic [GROUPS-1:0]          row_valid_ff, row_valid_in;
   logic [LINKS_PER_GROUP-1:0] row_rd_ff;
   logic [LINK_W-1:0]          link_rd_ff;
   logic                       rsp_valid_ff;
   logic [STAT_W-1:0]          status_ff;
   logic [IDX_W-1:0]           found_ff;
   logic [LINK_W-1:0]          link_ff;

   logic [GRP_W-1:0]           idx_row;
   logic [OFS_W-1:0]           idx_ofs;
   logic [GRP_W-1:0]           row_addr;
   logic [GRP_W-1:0]           row_sel;
   logic                       row_we;
   logic [LINKS_PER_GROUP-1:0] row_wdata;
   logic [LINKS_PER_GROUP-1:0] row_view;
   logic [LINKS_PER_GROUP-1:0] init_row;
   logic [LINKS_PER_GROUP-1:0] hit_vec;
   logic [OFS_W:0]             scan_cnt;
   logic                       hit;
   logic [OFS_W-1:0]           hit_ofs;
   logic                       link_we;
   logic                       is_last_grp;
   logic                       out_load;
   logic [STAT_W-1:0]          out_status;
   logic [IDX_W-1:0]           out_found;
   logic [LINK_W-1:0]          out_link;

   assign idx_row = cur_ff.idx[OFS_W +: GRP_W];
   assign idx_ofs = cur_ff.idx[OFS_W-1:0];

   // a group never written holds the formatted pattern
   always_comb begin
      row_sel  = (st_ff == S_FCHK) ? grp_ff : idx_row;
      init_row = '1;
      if (row_sel == '0) begin
         init_row[0] = 1'b0;
      end
      row_view = row_valid_ff[row_sel] ? row_rd_ff : init_row;
   end

   always_comb begin
      is_last_grp = ({1'b0, grp_ff} == geom.groups - (GRP_W+1)'(1));
      scan_cnt    = is_last_grp ? geom.last_cnt : (OFS_W+1)'(LINKS_PER_GROUP);
      for (int j = 0; j < LINKS_PER_GROUP; j++) begin
         hit_vec[j] = row_view[j] && ({1'b0, OFS_W'(j)} < scan_cnt);
      end
      hit     = |hit_vec;
      hit_ofs = '0;
      for (int j = LINKS_PER_GROUP - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_ofs = OFS_W'(j);
         end
      end
   end

   always_comb begin
      st_in         = st_ff;
      cur_in        = cur_ff;
      grp_in        = grp_ff;
      vis_in        = vis_ff;
      last_group_in = last_group_ff;
      written0_in   = written0_ff;
      row_valid_in  = row_valid_ff;
      pop_ready     = 1'b0;
      out_load      = 1'b0;
      out_status    = ST_OK;
      out_found     = '0;
      out_link      = '0;
      row_addr      = idx_row;
      row_we        = 1'b0;
      row_wdata     = row_view;
      row_wdata[idx_ofs] = (cur_ff.val == FREE_MARK);
      link_we       = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (pop_valid && !rsp_valid_ff) begin
               pop_ready = 1'b1;
               cur_in    = pop_rec;
               unique case (pop_rec.kind)
                  KIND_PASS: begin
                     out_load   = 1'b1;
                     out_status = pop_rec.status;
                  end
                  KIND_FIND: begin
                     grp_in = last_group_ff;
                     st_in  = S_MOD;
                  end
                  default: st_in = S_ACC;
               endcase
            end
         end
         S_MOD: begin
            // start group is last_group modulo the group count
            if ({1'b0, grp_ff} >= geom.groups) begin
               grp_in = grp_ff - geom.groups[GRP_W-1:0];
            end else begin
               vis_in = '0;
               st_in  = S_FRD;
            end
         end
         S_FRD: begin
            row_addr = grp_ff;
            st_in    = S_FCHK;
         end
         S_FCHK: begin
            if (hit) begin
               out_load      = 1'b1;
               out_found     = {grp_ff, hit_ofs};
               last_group_in = grp_ff;
               st_in         = S_IDLE;
            end else if ({1'b0, vis_ff} == geom.groups - (GRP_W+1)'(1)) begin
               out_load   = 1'b1;
               out_status = ST_NO_FREE;
               st_in      = S_IDLE;
            end else begin
               vis_in = vis_ff + GRP_W'(1);
               grp_in = is_last_grp ? '0 : grp_ff + GRP_W'(1);
               st_in  = S_FRD;
            end
         end
         S_ACC: begin
            st_in = S_DO;
         end
         S_DO: begin
            out_load = 1'b1;
            st_in    = S_IDLE;
            if (cur_ff.kind == KIND_SET) begin
               row_we                = 1'b1;
               link_we               = 1'b1;
               row_valid_in[idx_row] = 1'b1;
               if (cur_ff.idx == '0) begin
                  written0_in = 1'b1;
               end
            end else if (row_view[idx_ofs]) begin
               out_link = FREE_MARK;
            end else if (cur_ff.idx == '0 && !written0_ff) begin
               out_link = LAST_MARK;
            end else begin
               out_link = link_rd_ff;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         free_mem[row_addr] <= row_wdata;
      end
      row_rd_ff <= free_mem[row_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[cur_ff.idx] <= cur_ff.val;
      end
      link_rd_ff <= link_mem[cur_ff.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         last_group_ff <= '0;
         written0_ff   <= 1'b0;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         last_group_ff <= last_group_in;
         written0_ff   <= written0_in;
         row_valid_ff  <= row_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      grp_ff <= grp_in;
      vis_ff <= vis_in;
      if (out_load) begin
         status_ff <= out_status;
         found_ff  <= out_found;
         link_ff   <= out_link;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({link_ff, found_ff, status_ff});

endmodule
`default_nettype wire

>>> hdl/cluster_link_table_next_fit.sv
// set and get pass through the access and do states; failed or undefined items are answered from idle
// find: reduce the start group modulo the group count, then read and check one
//   128-link free-map row per group scanned
// throughput: one item at a time, the next starts the cycle after its result is taken;
//   a 2-entry queue decouples input acceptance from the table engine
// reset: synchronous; per-group valid bits format the table at once; mounted 1, total 4096
`default_nettype none
module cluster_link_table_next_fit
   import clnf_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire [REQ_W-1:0]  req_tdata,   // command, cluster_index, link_value
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // status, found_index, link_read
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire              csr_index,
   input  wire [TOT_W-1:0]  csr_data
);

   logic     push_valid;
   logic     push_ready;
   rec_type  push_rec;
   logic     pop_valid;
   logic     pop_ready;
   rec_type  pop_rec;
   geom_type geom;

   clnf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .geom       (geom)
   );

   clnf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   clnf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec),
      .geom       (geom),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
